// File: hdl/idle_time_utilization_monitor_top_macros.svh
// Assertion macros used by the checker file of the utilization monitor.
`ifndef IDLE_TIME_UTILIZATION_MONITOR_TOP_MACROS_SVH
`define IDLE_TIME_UTILIZATION_MONITOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define ITUM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define ITUM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/itum_pkg.sv
// Types and constants of the idle-time utilization monitor.
`default_nettype none
package itum_pkg;
	localparam int SAMPLE_W   = 32;
	localparam int ACC_W      = 32;
	localparam int GAP_W      = 16;
	localparam int IVL_W      = 32;
	localparam int PCT_W      = 7;
	localparam int PCT_SCALE  = 100;
	localparam int DIV_STEPS  = 7;
	localparam int DIV_W      = 39;
	localparam int FIFO_DEPTH = 2;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [ACC_W-1:0] ACC_MAX      = '1;
	localparam logic [GAP_W-1:0] IDLE_GAP_RST = 16'd20;
	localparam logic [IVL_W-1:0] IVL_RST      = 32'd500000;

	localparam logic REG_IDLE_GAP = 1'b0;
	localparam logic REG_INTERVAL = 1'b1;

	typedef struct packed {
		logic [GAP_W-1:0] idle_gap_max;
		logic [IVL_W-1:0] report_interval;
	} itum_cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0] idle;
		logic [ACC_W-1:0] total;
	} itum_pair_t;
endpackage
`default_nettype wire

// File: hdl/itum_if.sv
// Valid/ready channel interfaces for timer samples and utilization results.
`default_nettype none
interface itum_sample_if;
	import itum_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_time;
	modport source(output valid, output sample_time, input ready);
	modport sink(input valid, input sample_time, output ready);
endinterface

interface itum_result_if;
	import itum_pkg::*;
	logic             valid;
	logic             ready;
	logic [PCT_W-1:0] idle_percent;
	logic [ACC_W-1:0] idle_ticks_out;
	logic [ACC_W-1:0] total_ticks_out;
	modport source(output valid, output idle_percent, output idle_ticks_out,
		output total_ticks_out, input ready);
	modport sink(input valid, input idle_percent, input idle_ticks_out,
		input total_ticks_out, output ready);
endinterface
`default_nettype wire

// File: hdl/itum_front.sv
// Sample front end: gap accounting, wrap handling and report detection.
`default_nettype none
module itum_front #(
	parameter int TIME_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	itum_sample_if.sink             in_ch,
	input  wire itum_pkg::itum_cfg_t cfg,
	input  wire logic               full,
	output logic                    push,
	output itum_pkg::itum_pair_t    push_data
);
	import itum_pkg::*;

	localparam int NOW_W = (TIME_BITS < SAMPLE_W) ? TIME_BITS : SAMPLE_W;
	localparam int SUM_W = ACC_W + 1;

	logic [NOW_W-1:0] prev_q, last_q;
	logic [ACC_W-1:0] total_q, idle_q;
	logic             resync_q, started_q;

	logic [NOW_W-1:0] now, base, gap;
	logic [SUM_W-1:0] tot_sum, idl_sum, limit;
	logic [ACC_W-1:0] tot_new, idl_new;
	logic             accept, wrap, is_idle, report;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		now     = NOW_W'(in_ch.sample_time);
		base    = resync_q ? now : prev_q;
		wrap    = now < base;
		gap     = now - base;
		tot_sum = SUM_W'(total_q) + SUM_W'(gap);
		idl_sum = SUM_W'(idle_q) + SUM_W'(gap);
		tot_new = tot_sum[ACC_W] ? ACC_MAX : tot_sum[ACC_W-1:0];
		is_idle = SUM_W'(gap) <= SUM_W'(cfg.idle_gap_max);
		idl_new = !is_idle ? idle_q : (idl_sum[ACC_W] ? ACC_MAX : idl_sum[ACC_W-1:0]);
		limit   = SUM_W'(last_q) + SUM_W'(cfg.report_interval);
		report  = started_q && !wrap && (SUM_W'(now) > limit);
	end

	assign push            = accept && report;
	assign push_data.idle  = idl_new;
	assign push_data.total = tot_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			last_q    <= '0;
			total_q   <= '0;
			idle_q    <= '0;
			resync_q  <= 1'b0;
			started_q <= 1'b0;
		end else if (accept) begin
			prev_q <= now;
			if (!started_q) begin
				started_q <= 1'b1;
			end else if (wrap) begin
				last_q   <= now;
				resync_q <= 1'b0;
			end else if (report) begin
				last_q   <= now;
				total_q  <= '0;
				idle_q   <= '0;
				resync_q <= 1'b1;
			end else begin
				total_q  <= tot_new;
				idle_q   <= idl_new;
				resync_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/itum_fifo.sv
// Short register queue between the front end and the percentage unit.
`default_nettype none
module itum_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire itum_pkg::itum_pair_t push_data,
	input  wire logic            pop,
	output itum_pkg::itum_pair_t pop_data,
	output logic                 full,
	output logic                 empty
);
	import itum_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	itum_pair_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/itum_back.sv
// Back end: scales the idle count and divides it by the total, one bit per cycle.
`default_nettype none
module itum_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            empty,
	input  wire itum_pkg::itum_pair_t pop_data,
	output logic                 pop,
	itum_result_if.source        out_ch
);
	import itum_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} itum_state_t;

	itum_state_t      state_q;
	logic [ACC_W-1:0] idl_q, tot_q;
	logic [DIV_W-1:0] rem_q, dvs_q;
	logic [PCT_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fits;

	assign pop  = (state_q == ST_IDLE) && !empty;
	assign fits = rem_q >= dvs_q;

	assign out_ch.valid           = state_q == ST_OUT;
	assign out_ch.idle_percent    = (tot_q == '0) ? '0 : quo_q;
	assign out_ch.idle_ticks_out  = idl_q;
	assign out_ch.total_ticks_out = tot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (!empty) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= ST_OUT;
				ST_OUT:  if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idl_q <= pop_data.idle;
				tot_q <= pop_data.total;
			end
			ST_MUL: begin
				rem_q <= DIV_W'(idl_q) * DIV_W'(PCT_SCALE);
				dvs_q <= DIV_W'(tot_q) << (DIV_STEPS - 1);
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				if (fits) begin
					rem_q <= rem_q - dvs_q;
				end
				quo_q <= {quo_q[PCT_W-2:0], fits};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// File: hdl/idle_time_utilization_monitor_top.sv
// Top level of the idle-time utilization monitor with its register port.
//
//   channel   direction  contents
//   in_ch     in         sample_time, timer value in ticks
//   out_ch    out        idle_percent, idle_ticks_out, total_ticks_out
//   APB       in/out     idle_gap_max at 0x0, report_interval at 0x4
//
// A sample is taken while the two-entry result queue has room.
// In the back end a report passes through a pop, the scaling multiply and seven
// restoring division steps, then it waits in the output register.
// Reset clears the front-end counters and times and the queue pointers; no clearing pass is needed.
// A stalled result fills the queue, after which in_ch.ready falls.
`default_nettype none
module idle_time_utilization_monitor_top #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	itum_sample_if.sink                       in_ch,
	itum_result_if.source                     out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [itum_pkg::APB_AW-1:0]  paddr,
	input  wire logic [itum_pkg::APB_DW-1:0]  pwdata,
	output logic      [itum_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);
	import itum_pkg::*;

	itum_cfg_t  cfg_q;
	itum_pair_t push_data, pop_data;
	logic       push, pop, full, empty, wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_INTERVAL) ? APB_DW'(cfg_q.report_interval)
	                                           : APB_DW'(cfg_q.idle_gap_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_gap_max    <= IDLE_GAP_RST;
			cfg_q.report_interval <= IVL_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_IDLE_GAP: cfg_q.idle_gap_max    <= pwdata[GAP_W-1:0];
				REG_INTERVAL: cfg_q.report_interval <= pwdata[IVL_W-1:0];
				default:      cfg_q                 <= cfg_q;
			endcase
		end
	end

	itum_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	itum_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	itum_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.out_ch   (out_ch)
	);
endmodule
`default_nettype wire

// File: hdl/itum_checker.sv
// Port-level checker of the utilization monitor and its bind to the top level.
`default_nettype none
`include "idle_time_utilization_monitor_top_macros.svh"
module itum_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [itum_pkg::PCT_W-1:0]  idle_percent,
	input wire logic [itum_pkg::ACC_W-1:0]  idle_ticks_out,
	input wire logic [itum_pkg::ACC_W-1:0]  total_ticks_out
);
	import itum_pkg::*;

	`ITUM_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
	`ITUM_ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(idle_percent) && $stable(idle_ticks_out) && $stable(total_ticks_out), "result changed while stalled")
	`ITUM_ASSERT_SAME(a_idle_le_total, out_valid, idle_ticks_out <= total_ticks_out && idle_percent <= PCT_W'(PCT_SCALE), "idle count or percentage out of range")
	`ITUM_ASSERT_SAME(a_empty_interval, out_valid && total_ticks_out == '0, idle_percent == '0, "empty interval gave a nonzero percentage")
endmodule

bind idle_time_utilization_monitor_top itum_checker u_itum_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.idle_percent    (out_ch.idle_percent),
	.idle_ticks_out  (out_ch.idle_ticks_out),
	.total_ticks_out (out_ch.total_ticks_out)
);
`default_nettype wire

// File: bench/idle_time_utilization_monitor_top_tb.sv
// Self-checking testbench for the idle-time utilization monitor.
`timescale 1ns / 1ps
module idle_time_utilization_monitor_top_tb;
	import itum_pkg::*;

	localparam logic [APB_AW-1:0] ADDR_IDLE_GAP = APB_AW'(4 * REG_IDLE_GAP);
	localparam logic [APB_AW-1:0] ADDR_INTERVAL = APB_AW'(4 * REG_INTERVAL);

	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic [ACC_W-1:0] idle;
		logic [ACC_W-1:0] total;
	} util_report_t;

	class util_scoreboard;
		logic [GAP_W-1:0]    idle_gap_max;
		logic [IVL_W-1:0]    report_interval;
		logic [SAMPLE_W-1:0] prev_time;
		logic [SAMPLE_W-1:0] last_report_time;
		logic [ACC_W-1:0]    total_acc;
		logic [ACC_W-1:0]    idle_acc;
		bit                  resync_pending;
		bit                  started;
		util_report_t        pending[$];
		int                  mismatches;
		int                  reports_checked;
		int                  empty_reports;
		int                  saturations;
		int                  wraps;

		function new();
			idle_gap_max     = IDLE_GAP_RST;
			report_interval  = IVL_RST;
			prev_time        = '0;
			last_report_time = '0;
			total_acc        = '0;
			idle_acc         = '0;
			resync_pending   = 1'b0;
			started          = 1'b0;
			mismatches       = 0;
			reports_checked  = 0;
			empty_reports    = 0;
			saturations      = 0;
			wraps            = 0;
		endfunction

		task flag(string what);
			$display("ERROR at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		function logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, logic [SAMPLE_W-1:0] add);
			logic [ACC_W:0] sum;
			sum = {1'b0, acc} + {1'b0, add};
			if (sum[ACC_W]) begin
				saturations++;
				return ACC_MAX;
			end
			return sum[ACC_W-1:0];
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] now);
			logic [SAMPLE_W-1:0] gap;
			logic [63:0]         scaled;
			util_report_t        rep;
			if (!started) begin
				started   = 1'b1;
				prev_time = now;
				return;
			end
			if (resync_pending) begin
				prev_time      = now;
				resync_pending = 1'b0;
			end
			if (now < prev_time) begin
				prev_time        = now;
				last_report_time = now;
				wraps++;
				return;
			end
			gap       = now - prev_time;
			total_acc = sat_add(total_acc, gap);
			if (gap <= {16'h0, idle_gap_max})
				idle_acc = sat_add(idle_acc, gap);
			prev_time = now;
			if ({1'b0, now} > {1'b0, last_report_time} + {1'b0, report_interval}) begin
				scaled = 64'd0;
				if (total_acc != '0)
					scaled = ({32'h0, idle_acc} * PCT_SCALE) / {32'h0, total_acc};
				rep.pct   = scaled[PCT_W-1:0];
				rep.idle  = idle_acc;
				rep.total = total_acc;
				pending.push_back(rep);
				if (total_acc == '0)
					empty_reports++;
				last_report_time = now;
				total_acc        = '0;
				idle_acc         = '0;
				resync_pending   = 1'b1;
			end
		endfunction

		task check_report(util_report_t got);
			util_report_t want;
			if (pending.size() == 0) begin
				flag($sformatf("unexpected result pct=%0d idle=%0d total=%0d",
					got.pct, got.idle, got.total));
				return;
			end
			want = pending.pop_front();
			reports_checked++;
			if (got.pct !== want.pct)
				flag($sformatf("idle_percent %0d, expected %0d", got.pct, want.pct));
			if (got.idle !== want.idle)
				flag($sformatf("idle_ticks_out %0d, expected %0d", got.idle, want.idle));
			if (got.total !== want.total)
				flag($sformatf("total_ticks_out %0d, expected %0d", got.total, want.total));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic [SAMPLE_W-1:0] timer_now;
	util_scoreboard     sb;

	itum_sample_if in_ch();
	itum_result_if out_ch();

	idle_time_utilization_monitor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TIMEOUT at %0t ns with %0d results outstanding", $time, sb.pending.size());
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_sample(in_ch.sample_time);
	end

	always @(posedge clk) begin : result_monitor
		util_report_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pct   = out_ch.idle_percent;
			got.idle  = out_ch.idle_ticks_out;
			got.total = out_ch.total_ticks_out;
			sb.check_report(got);
		end
	end

	initial begin : result_pacing
		int unsigned mode;
		int unsigned left;
		mode = 0;
		left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(10, 150);
			end
			left--;
			case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 1) == 1);
				2: out_ch.ready <= ($urandom_range(0, 7) == 0);
				default: out_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_IDLE_GAP)
			sb.idle_gap_max = data[GAP_W-1:0];
		else if (addr == ADDR_INTERVAL)
			sb.report_interval = data[IVL_W-1:0];
	endtask

	task automatic set_config(input logic [GAP_W-1:0] gap_max, input logic [IVL_W-1:0] ivl);
		apb_write(ADDR_IDLE_GAP, {{(APB_DW-GAP_W){1'b0}}, gap_max});
		apb_write(ADDR_INTERVAL, ivl);
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] t);
		in_ch.valid       <= 1'b1;
		in_ch.sample_time <= t;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain(input int settle);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] next_sample(input logic [GAP_W-1:0] gap_max);
		int unsigned         r;
		logic [SAMPLE_W-1:0] lim;
		r   = $urandom_range(0, 99);
		lim = {16'h0, gap_max};
		if (r < 55)
			timer_now = timer_now + $urandom_range(0, lim);
		else if (r < 75)
			timer_now = timer_now + lim + $urandom_range(1, 3 * (lim + 1));
		else if (r < 82)
			timer_now = timer_now + lim;
		else if (r < 87)
			timer_now = timer_now + lim + 1;
		else if (r < 93)
			timer_now = timer_now + $urandom();
		else if (r < 97)
			timer_now = $urandom_range(0, timer_now);
		else
			timer_now = $urandom();
		return timer_now;
	endfunction

	task automatic run_stream(input int n, input logic [GAP_W-1:0] gap_max, input bit steady);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if (!steady)
					idle_cycles($urandom_range(0, 6));
			end
			send_sample(next_sample(gap_max));
			burst--;
		end
	endtask

	initial begin : stimulus
		logic [GAP_W-1:0] gap_max;
		logic [IVL_W-1:0] ivl;
		logic [IVL_W-1:0] span;
		sb                = new();
		arst_n            = 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		in_ch.valid       <= 1'b0;
		in_ch.sample_time <= '0;
		timer_now         = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero threshold, no reports: a wrap with saturation of the total afterwards.
		set_config(16'd0, 32'hFFFF_FFFF);
		send_sample(32'h0000_0010);
		send_sample(32'h0000_0010);
		send_sample(32'h0000_0011);
		send_sample(32'hFFFF_FFF0);
		send_sample(32'h0000_0003);
		send_sample(32'hA000_0000);
		drain(20);
		// Shortest interval: a saturated report, then an empty one.
		set_config(16'hFFFF, 32'd1);
		send_sample(32'hA000_0010);
		send_sample(32'hA000_0012);
		drain(20);
		set_config(16'hFFFF, 32'h0003_0000);
		send_sample(32'hA000_0100);
		send_sample(32'hA001_00FF);
		send_sample(32'hA002_0100);
		send_sample(32'hA003_0200);
		drain(20);
		set_config(16'd20, 32'd100);
		send_sample(32'hA003_0300);
		send_sample(32'hA003_0314);
		send_sample(32'hA003_0329);
		send_sample(32'hA003_03F1);
		drain(20);
		// Report threshold beyond the top of the timer range.
		set_config(16'd20, 32'h0000_0200);
		send_sample(32'hFFFF_FE00);
		send_sample(32'hFFFF_FF00);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0005);
		send_sample(32'h0000_0300);
		drain(20);
		timer_now = 32'h0000_0300;

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 3))
				0: gap_max = $urandom_range(0, 40);
				1: gap_max = $urandom_range(0, 65535);
				2: gap_max = IDLE_GAP_RST;
				default: gap_max = $urandom_range(100, 3000);
			endcase
			if (ph == 0)
				gap_max = '0;
			else if (ph == 1)
				gap_max = '1;
			span = {16'h0, gap_max} + 1;
			if ($urandom_range(0, 1) == 0)
				ivl = $urandom_range(1, 4 * span);
			else
				ivl = span * $urandom_range(5, 25);
			if (ph == 2)
				ivl = '1;
			else if (ph == 3)
				ivl = 32'd1;
			else if (ph == 4)
				ivl = IVL_RST;
			if (ph == 5)
				timer_now = 32'hFFFF_0000 - $urandom_range(0, 4096);
			set_config(gap_max, ivl);
			run_stream((ph == 2) ? 40 : 120, gap_max, (ph % 4) == 3);
			drain(20);
		end

		drain(30);
		if (sb.pending.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.pending.size()));
		$display("Checked %0d utilization reports (%0d over empty intervals).",
			sb.reports_checked, sb.empty_reports);
		$display("Covered %0d timer wraps and %0d saturating additions.",
			sb.wraps, sb.saturations);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// File: idle_time_utilization_monitor_top.f
+incdir+hdl
hdl/itum_pkg.sv
hdl/itum_if.sv
hdl/itum_front.sv
hdl/itum_fifo.sv
hdl/itum_back.sv
hdl/idle_time_utilization_monitor_top.sv
hdl/itum_checker.sv
bench/idle_time_utilization_monitor_top_tb.sv
